/* hdl/mfvf_pkg.sv */
package mfvf_pkg;

    localparam int MAX_ITEMS_DEF   = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int SAMPLE_WIDTH    = 32;
    localparam int COUNT_WIDTH     = 9;
    localparam int QUEUE_DEPTH     = 2;

    // One classified request handed from the front part to the back part.
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    last;
    } mfvf_req_t;

endpackage

/* hdl/mfvf_ram.sv */
module mfvf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/mfvf_queue.sv */
module mfvf_queue import mfvf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  mfvf_req_t in_req,
    output logic      out_valid,
    input  logic      out_ready,
    output mfvf_req_t out_req
);

    // Two-entry FIFO; front and back stall independently.
    mfvf_req_t slot_reg [QUEUE_DEPTH];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = slot_reg[rp_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wp_reg] <= in_req;
        end
    end

endmodule

/* hdl/mfvf_back.sv */
module mfvf_back import mfvf_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  mfvf_req_t               req,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [SAMPLE_WIDTH-1:0] res_value,
    output logic [COUNT_WIDTH-1:0]  res_count,
    output logic                    res_overflow
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam logic [NW-1:0] NMAX = NW'(MAX_ITEMS);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_OUTER = 3'd1;
    localparam logic [2:0] ST_INNER = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_SEND  = 3'd4;

    // Selection scan: for each stored entry i (outer), count entries equal
    // to it (inner). The candidate with the larger count, or the same count
    // and a smaller signed value, wins.
    logic [2:0]             st_reg, st_next;
    logic [NW-1:0]          n_reg, n_next;
    logic                   ovf_reg, ovf_next;
    logic [NW-1:0]          i_reg, i_next, j_reg, j_next;
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [NW-1:0]          cc_reg, cc_next;
    logic [VALUE_WIDTH-1:0] best_reg, best_next;
    logic [NW-1:0]          bc_reg, bc_next;
    logic                   rdv_reg, rdv_next;

    logic                   wr_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   take;

    assign req_ready = (st_reg == ST_LOAD);
    assign take      = req_valid & req_ready;
    assign wr_en     = take & (n_reg < NMAX);

    mfvf_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[AW-1:0]),
        .wr_data (VALUE_WIDTH'(req.value)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        st_next   = st_reg;
        n_next    = n_reg;
        ovf_next  = ovf_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        cand_next = cand_reg;
        cc_next   = cc_reg;
        best_next = best_reg;
        bc_next   = bc_reg;
        rdv_next  = 1'b0;
        rd_addr   = i_reg[AW-1:0];
        case (st_reg)
            ST_LOAD: begin
                if (take) begin
                    if (n_reg < NMAX) begin
                        n_next = n_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (req.last) begin
                        st_next = ST_OUTER;
                        i_next  = '0;
                        bc_next = '0;
                    end
                end
            end
            ST_OUTER: begin
                rd_addr = i_reg[AW-1:0];
                if (!rdv_reg) begin
                    rdv_next = 1'b1;
                end else begin
                    cand_next = rd_data;
                    cc_next   = '0;
                    j_next    = '0;
                    st_next   = ST_INNER;
                end
            end
            ST_INNER: begin
                // Read pipeline: issue j, data arrives next cycle.
                rd_addr  = j_reg[AW-1:0];
                rdv_next = (j_reg < n_reg);
                if (j_reg < n_reg) begin
                    j_next = j_reg + 1'b1;
                end
                if (rdv_reg && rd_data == cand_reg) begin
                    cc_next = cc_reg + 1'b1;
                end
                if (!rdv_reg && j_reg == n_reg) begin
                    st_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (cc_reg > bc_reg || (cc_reg == bc_reg
                        && $signed(cand_reg) < $signed(best_reg))) begin
                    best_next = cand_reg;
                    bc_next   = cc_reg;
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg) begin
                    st_next = ST_SEND;
                end else begin
                    st_next = ST_OUTER;
                end
            end
            ST_SEND: begin
                if (res_ready) begin
                    st_next  = ST_LOAD;
                    n_next   = '0;
                    ovf_next = 1'b0;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_LOAD;
            n_reg   <= '0;
            ovf_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            n_reg   <= n_next;
            ovf_reg <= ovf_next;
            rdv_reg <= rdv_next;
        end
        i_reg    <= i_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        cc_reg   <= cc_next;
        best_reg <= best_next;
        bc_reg   <= bc_next;
    end

    // The mode value leaves as its low bits, zero-filled above VALUE_WIDTH.
    assign res_valid    = (st_reg == ST_SEND);
    assign res_value    = SAMPLE_WIDTH'(best_reg);
    assign res_count    = COUNT_WIDTH'(bc_reg);
    assign res_overflow = ovf_reg;

endmodule

/* hdl/most_frequent_value_finder_core.sv */
// Throughput: one sample request per cycle while loading; the two-entry queue absorbs
// requests during the scan, after which input stalls until the result is taken.
// The scan is bound by the single read port of the sample store (one read per cycle).
// Reset: aresetn, synchronous and active low, empties the queue, the set count and overflow.
module most_frequent_value_finder_core import mfvf_pkg::*; #(
    parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_value[31:0]
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mode_value[31:0], mode_count[40:32], overflow[41], zeros
    output logic        m_tlast
);

    // Front part: the incoming request is classified (value and set end)
    // and pushed into the queue.
    mfvf_req_t front_req, back_req;
    logic      back_valid, back_ready;
    logic [SAMPLE_WIDTH-1:0] res_value;
    logic [COUNT_WIDTH-1:0]  res_count;
    logic                    res_overflow;

    assign front_req.value = s_tdata;
    assign front_req.last  = s_tlast;

    mfvf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (front_req),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_req   (back_req)
    );

    // Back part: stores the set and scans it for the mode.
    mfvf_back #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (back_valid),
        .req_ready    (back_ready),
        .req          (back_req),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_value    (res_value),
        .res_count    (res_count),
        .res_overflow (res_overflow)
    );

    assign m_tdata = {6'd0, res_overflow, res_count, res_value};
    assign m_tlast = 1'b1;

    // A result never appears with a zero count.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_count != '0))
        else $error("mode count is zero");

    // A pending result holds its value until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

/* verif/tb_most_frequent_value_finder_core.sv */
module tb_most_frequent_value_finder_core;
    import mfvf_pkg::*;

    localparam int STORE_DEPTH = MAX_ITEMS_DEF;

    typedef struct {
        logic [31:0] value;
        logic [8:0]  count;
        logic        ovf;
    } mode_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    // Predictor state: the samples held for the set that is still open.
    logic [31:0]  set_values[$];
    logic         set_dropped = 1'b0;
    mode_result_t pending_modes[$];
    int           error_total = 0;
    int           sets_closed = 0;
    int           results_seen = 0;
    bit           gaps_on = 1'b1;

    most_frequent_value_finder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    task automatic report_error(input string what);
        error_total++;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // Counts each distinct value; the smallest signed value wins any tie.
    function automatic mode_result_t compute_mode();
        int          occurrences[logic [31:0]];
        mode_result_t best;
        best.value = '0;
        best.count = '0;
        best.ovf = set_dropped;
        foreach (set_values[i]) occurrences[set_values[i]]++;
        foreach (occurrences[v]) begin
            if (occurrences[v] > best.count ||
                (occurrences[v] == best.count && $signed(v) < $signed(best.value))) begin
                best.value = v;
                best.count = 9'(occurrences[v]);
            end
        end
        return best;
    endfunction

    // Valid stays high after the request is taken; the next call or the
    // caller lowers it, so it is driven once per time step.
    task automatic send_sample(input logic [31:0] value, input logic last);
        while (gaps_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (set_values.size() < STORE_DEPTH) set_values.push_back(value);
        else set_dropped = 1'b1;
        if (last) begin
            pending_modes.push_back(compute_mode());
            set_values.delete();
            set_dropped = 1'b0;
            sets_closed++;
        end
    endtask

    // Ready toggles at random; results are checked against the oldest prediction.
    always @(posedge aclk) begin
        mode_result_t exp_r;
        m_tready <= aresetn && !(gaps_on && $urandom_range(99) < 27);
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_modes.size() == 0) begin
                report_error("result with no open prediction");
            end else begin
                exp_r = pending_modes.pop_front();
                if (m_tdata[31:0] !== exp_r.value)
                    report_error($sformatf("mode value %0d, wanted %0d",
                        $signed(m_tdata[31:0]), $signed(exp_r.value)));
                if (m_tdata[40:32] !== exp_r.count)
                    report_error($sformatf("mode count %0d, wanted %0d",
                        m_tdata[40:32], exp_r.count));
                if (m_tdata[41] !== exp_r.ovf)
                    report_error($sformatf("overflow %b, wanted %b", m_tdata[41], exp_r.ovf));
                if (m_tdata[47:42] !== '0) report_error("padding bits not zero");
            end
        end
    end

    function automatic logic [31:0] pick_value(input int pool);
        case ($urandom_range(3))
            0: return 32'h8000_0000 + $urandom_range(pool);
            1: return 32'h7fff_ffff - $urandom_range(pool);
            2: return $urandom_range(pool) - pool / 2;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_extremes();
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7fff_ffff, 1'b1);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
    endtask

    task automatic test_ties();
        // Two values each twice: the smaller, negative one must win.
        send_sample(32'd5, 1'b0);
        send_sample(32'hffff_fffb, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'hffff_fffb, 1'b0);
        send_sample(32'd9, 1'b1);
        send_sample(32'hdead_beef, 1'b0);
        send_sample(32'h2152_4110, 1'b0);
        send_sample(32'hdead_beef, 1'b1);
    endtask

    // Fills the store past capacity so the trailing items are dropped;
    // a dropped item still closes the set.
    task automatic test_overflow();
        for (int i = 0; i < STORE_DEPTH + 3; i++)
            send_sample(i % 5 == 0 ? 32'h8000_0001 : $urandom(), i == STORE_DEPTH + 2);
    endtask

    task automatic test_random_sets(input int budget);
        int sent = 0;
        int len, pool;
        while (sent < budget) begin
            gaps_on = !(sent > budget / 2 && sent < budget / 2 + 60);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
            pool = $urandom_range(1) ? 3 : 1000;
            for (int i = 0; i < len; i++) send_sample(pick_value(pool), i == len - 1);
            sent += len;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_ties();
        test_random_sets(90);
        test_overflow();
        test_random_sets(90);
        s_tvalid <= 1'b0;
        while (pending_modes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Closed %0d sets and checked %0d results, covering sign extremes, ties,",
            sets_closed, results_seen);
        $display("store overflow and random sets with and without flow-control gaps.");
        if (error_total == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* most_frequent_value_finder_core.f */
hdl/mfvf_pkg.sv
hdl/mfvf_ram.sv
hdl/mfvf_queue.sv
hdl/mfvf_back.sv
hdl/most_frequent_value_finder_core.sv
verif/tb_most_frequent_value_finder_core.sv
